[hdl/xur_pkg.sv]
package xur_pkg;

  localparam int unsigned WordW = 64;

  localparam logic [WordW-1:0] GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MIX_C1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MIX_C2  = 64'h94D0_49BB_1331_11EB;
  localparam logic [WordW-1:0] MASK32  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [WordW-1:0] SIGN64  = 64'h8000_0000_0000_0000;
  localparam logic [WordW-1:0] SIGN32  = 64'h0000_0000_8000_0000;

  typedef enum logic [1:0] {
    CMD_RAW    = 2'd0,
    CMD_RANGE  = 2'd1,
    CMD_SIGNED = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_LOAD_ADD,
    ST_LOAD_M1,
    ST_LOAD_M2,
    ST_LOAD_FIX,
    ST_IDLE,
    ST_PREP,
    ST_THR_GO,
    ST_THR,
    ST_DRAW,
    ST_DRAW2,
    ST_CHECK,
    ST_MODR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } xur_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] res;
  } xur_rsp_t;

endpackage

[hdl/xur_mul.sv]
module xur_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  xur_pkg::xur_req_t  req,
  output xur_pkg::xur_rsp_t  rsp
);

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // one multiplier bit per cycle, low 64 bits of the product
  always_comb begin
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      acc_nxt  = '0;
      x_nxt    = req.x;
      y_nxt    = req.y;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (y_r[0] ? x_r : 64'd0);
      x_nxt   = {x_r[62:0], 1'b0};
      y_nxt   = {1'b0, y_r[63:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

[hdl/xur_mod.sv]
module xur_mod (
  input  logic               clk,
  input  logic               rst_n,
  input  xur_pkg::xur_req_t  req,
  output xur_pkg::xur_rsp_t  rsp
);

  logic [63:0] n_r, n_nxt;
  logic [63:0] d_r, d_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, n_r[63]};
    rem_sub  = rem_sh - {1'b0, d_r};
    if (req.start && !busy_r) begin
      n_nxt    = req.x;
      d_nxt    = req.y;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt   = {n_r[62:0], 1'b0};
      rem_nxt = (rem_sh >= {1'b0, d_r}) ? rem_sub[63:0] : rem_sh[63:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = rem_r;

endmodule

[hdl/xoshiro_uniform_rng_core.sv]
// channel  | handshake           | payload
// cfg      | cfg_valid/cfg_ready | cfg_seed
// in       | in_valid/in_ready   | in_command, in_wide, in_bound_a, in_bound_b
// out      | out_valid/out_ready | out_value, out_state_digest
//
// Raw draw, or full range: PREP, DRAW, DRAW2, then FINISH into the output.
// Range draw: THR_GO/THR and CHECK/MODR run the two bit-serial remainder
// passes of the shared divider; a draw below the threshold returns to DRAW.
// Reset and each seed transaction reload the state with four splitmix
// rounds, each two passes of the bit-serial multiplier.
// A result waiting on out_ready holds the next item in its final state.
module xoshiro_uniform_rng_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic        in_wide,
  input  logic [63:0] in_bound_a,
  input  logic [63:0] in_bound_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic [63:0] out_state_digest
);

  xur_pkg::state_t state_r, state_nxt;
  xur_pkg::cmd_t   cmd_r, cmd_nxt;
  xur_pkg::xur_req_t mul_req, mod_req;
  xur_pkg::xur_rsp_t mul_rsp, mod_rsp;

  logic [63:0] words_r [4];
  logic [63:0] words_nxt [4];
  logic [63:0] sm_r, sm_nxt;
  logic [1:0]  w_r, w_nxt;
  logic        wide_r, wide_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt;
  logic [63:0] lo_r, lo_nxt, range_r, range_nxt, flip_r, flip_nxt;
  logic [63:0] thr_r, thr_nxt, p_r, p_nxt, r_r, r_nxt, res_r, res_nxt;
  logic        rawm_r, rawm_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt, out_dig_r, out_dig_nxt;

  logic [63:0] mask, in_mask, flip, lo, hi, sum, z, q, v;
  logic        is_rng;

  assign mask    = wide_r ? '1 : xur_pkg::MASK32;
  assign in_mask = in_wide ? '1 : xur_pkg::MASK32;

  assign cfg_ready = (state_r == xur_pkg::ST_IDLE);
  assign in_ready  = (state_r == xur_pkg::ST_IDLE) && !cfg_valid;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    words_nxt     = words_r;
    sm_nxt        = sm_r;
    w_nxt         = w_r;
    wide_nxt      = wide_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    lo_nxt        = lo_r;
    range_nxt     = range_r;
    flip_nxt      = flip_r;
    thr_nxt       = thr_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    res_nxt       = res_r;
    rawm_nxt      = rawm_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_dig_nxt   = out_dig_r;
    mul_req       = '0;
    mod_req       = '0;
    flip          = '0;
    lo            = '0;
    hi            = '0;
    sum           = '0;
    z             = '0;
    q             = {p_r[56:0], p_r[63:57]};
    v             = q + {q[60:0], 3'b000};
    is_rng        = (cmd_r == xur_pkg::CMD_RANGE) || (cmd_r == xur_pkg::CMD_SIGNED);
    case (state_r)
      xur_pkg::ST_LOAD_ADD: begin
        sm_nxt        = sm_r + xur_pkg::GOLDEN;
        z             = sm_nxt ^ (sm_nxt >> 30);
        mul_req.start = 1'b1;
        mul_req.x     = z;
        mul_req.y     = xur_pkg::MIX_C1;
        state_nxt     = xur_pkg::ST_LOAD_M1;
      end
      xur_pkg::ST_LOAD_M1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.x     = mul_rsp.res ^ (mul_rsp.res >> 27);
          mul_req.y     = xur_pkg::MIX_C2;
          state_nxt     = xur_pkg::ST_LOAD_M2;
        end
      end
      xur_pkg::ST_LOAD_M2: begin
        if (mul_rsp.done) begin
          words_nxt[w_r] = mul_rsp.res ^ (mul_rsp.res >> 31);
          w_nxt          = w_r + 2'd1;
          state_nxt      = (w_r == 2'd3) ? xur_pkg::ST_LOAD_FIX : xur_pkg::ST_LOAD_ADD;
        end
      end
      xur_pkg::ST_LOAD_FIX: begin
        if ((words_r[0] | words_r[1] | words_r[2] | words_r[3]) == 64'd0) begin
          words_nxt[0] = 64'd1;
        end
        state_nxt = xur_pkg::ST_IDLE;
      end
      xur_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          sm_nxt    = cfg_seed;
          w_nxt     = '0;
          state_nxt = xur_pkg::ST_LOAD_ADD;
        end else if (in_valid) begin
          cmd_nxt   = xur_pkg::cmd_t'(in_command);
          wide_nxt  = in_wide;
          a_nxt     = in_bound_a & in_mask;
          b_nxt     = in_bound_b & in_mask;
          state_nxt = xur_pkg::ST_PREP;
        end
      end
      xur_pkg::ST_PREP: begin
        if (cmd_r == xur_pkg::CMD_SIGNED) begin
          flip = wide_r ? xur_pkg::SIGN64 : xur_pkg::SIGN32;
        end
        lo = a_r ^ flip;
        hi = b_r ^ flip;
        if (lo > hi) begin
          lo = b_r ^ flip;
          hi = a_r ^ flip;
        end
        flip_nxt  = flip;
        lo_nxt    = lo;
        range_nxt = (hi - lo + 64'd1) & mask;
        rawm_nxt  = !is_rng || ((lo == 64'd0) && (hi == mask));
        state_nxt = rawm_nxt ? xur_pkg::ST_DRAW : xur_pkg::ST_THR_GO;
      end
      xur_pkg::ST_THR_GO: begin
        mod_req.start = 1'b1;
        mod_req.x     = (64'd0 - range_r) & mask;
        mod_req.y     = range_r;
        state_nxt     = xur_pkg::ST_THR;
      end
      xur_pkg::ST_THR: begin
        if (mod_rsp.done) begin
          thr_nxt   = mod_rsp.res;
          state_nxt = xur_pkg::ST_DRAW;
        end
      end
      xur_pkg::ST_DRAW: begin
        p_nxt        = words_r[1] + {words_r[1][61:0], 2'b00};
        words_nxt[2] = words_r[2] ^ words_r[0] ^ {words_r[1][46:0], 17'd0};
        words_nxt[1] = words_r[1] ^ words_r[2] ^ words_r[0];
        words_nxt[0] = words_r[0] ^ words_r[3] ^ words_r[1];
        z            = words_r[3] ^ words_r[1];
        words_nxt[3] = {z[18:0], z[63:19]};
        state_nxt    = xur_pkg::ST_DRAW2;
      end
      xur_pkg::ST_DRAW2: begin
        r_nxt = wide_r ? v : {32'd0, v[63:32]};
        if (rawm_r) begin
          res_nxt   = r_nxt;
          state_nxt = xur_pkg::ST_FINISH;
        end else begin
          state_nxt = xur_pkg::ST_CHECK;
        end
      end
      xur_pkg::ST_CHECK: begin
        if (r_r < thr_r) begin
          state_nxt = xur_pkg::ST_DRAW;
        end else begin
          mod_req.start = 1'b1;
          mod_req.x     = r_r;
          mod_req.y     = range_r;
          state_nxt     = xur_pkg::ST_MODR;
        end
      end
      xur_pkg::ST_MODR: begin
        if (mod_rsp.done) begin
          sum       = lo_r + mod_rsp.res;
          res_nxt   = (sum ^ flip_r) & mask;
          state_nxt = xur_pkg::ST_FINISH;
        end
      end
      xur_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r & mask;
          out_dig_nxt   = words_r[0] ^ words_r[1] ^ words_r[2] ^ words_r[3];
          state_nxt     = xur_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = xur_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xur_pkg::ST_LOAD_ADD;
      sm_r        <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sm_r        <= sm_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    words_r     <= words_nxt;
    wide_r      <= wide_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    lo_r        <= lo_nxt;
    range_r     <= range_nxt;
    flip_r      <= flip_nxt;
    thr_r       <= thr_nxt;
    p_r         <= p_nxt;
    r_r         <= r_nxt;
    res_r       <= res_nxt;
    rawm_r      <= rawm_nxt;
    out_value_r <= out_value_nxt;
    out_dig_r   <= out_dig_nxt;
  end

  xur_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  xur_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_state_digest = out_dig_r;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xur_pkg::ST_FINISH && out_valid_r && !out_ready)
      |=> (state_r == xur_pkg::ST_FINISH))
    else $error("result dropped while output register full");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (state_r == xur_pkg::ST_LOAD_ADD && w_r == 2'd0))
    else $error("seed transaction did not restart state load");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xur_pkg::ST_IDLE)
      |-> ((words_r[0] | words_r[1] | words_r[2] | words_r[3]) != 64'd0))
    else $error("generator state all zero");
`endif

endmodule

[bench/xoshiro_uniform_rng_core_tb.sv]
`timescale 1ns / 1ps

module xoshiro_uniform_rng_core_tb;

  typedef struct {
    logic [63:0] value;
    logic [63:0] digest;
  } draw_result_t;

  class draw_scoreboard;
    logic [63:0] words[4];
    draw_result_t pending[$];
    int errors;

    function new();
      errors = 0;
      reseed(64'd0);
    endfunction

    function logic [63:0] rotl(logic [63:0] v, int k);
      return (v << k) | (v >> (64 - k));
    endfunction

    function void reseed(logic [63:0] s);
      logic [63:0] acc, z;
      acc = s;
      for (int i = 0; i < 4; i++) begin
        acc = acc + xur_pkg::GOLDEN;
        z = acc;
        z = (z ^ (z >> 30)) * xur_pkg::MIX_C1;
        z = (z ^ (z >> 27)) * xur_pkg::MIX_C2;
        words[i] = z ^ (z >> 31);
      end
      if ((words[0] | words[1] | words[2] | words[3]) == 64'd0) words[0] = 64'd1;
    endfunction

    function logic [63:0] next_raw(bit wide);
      logic [63:0] o, t;
      o = rotl(words[1] * 64'd5, 7) * 64'd9;
      t = words[1] << 17;
      words[2] ^= words[0];
      words[3] ^= words[1];
      words[1] ^= words[2];
      words[0] ^= words[3];
      words[2] ^= t;
      words[3] = rotl(words[3], 45);
      return wide ? o : (o >> 32);
    endfunction

    function void note_request(xur_pkg::cmd_t cmd, bit wide,
                               logic [63:0] a, logic [63:0] b);
      logic [63:0] mask, flip, lo, hi, tmp, span, thresh, r, v;
      draw_result_t e;
      mask = wide ? ~64'd0 : xur_pkg::MASK32;
      flip = 64'd0;
      if (cmd == xur_pkg::CMD_RANGE || cmd == xur_pkg::CMD_SIGNED) begin
        if (cmd == xur_pkg::CMD_SIGNED) flip = wide ? xur_pkg::SIGN64 : xur_pkg::SIGN32;
        lo = (a & mask) ^ flip;
        hi = (b & mask) ^ flip;
        if (lo > hi) begin
          tmp = lo; lo = hi; hi = tmp;
        end
        span = (hi - lo + 64'd1) & mask;
        if ((lo == 0 && hi == mask) || span == 0) begin
          v = next_raw(wide);
        end else begin
          thresh = ((64'd0 - span) & mask) % span;
          r = next_raw(wide);
          while (r < thresh) r = next_raw(wide);
          v = (((lo + r % span) & mask) ^ flip) & mask;
        end
      end else begin
        v = next_raw(wide);
      end
      e.value = v & mask;
      e.digest = words[0] ^ words[1] ^ words[2] ^ words[3];
      pending.push_back(e);
    endfunction

    function void check_result(logic [63:0] value, logic [63:0] digest);
      draw_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result value %h", value);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (value !== e.value) begin
        $error("value: expected %h actual %h", e.value, value);
        errors++;
      end
      if (digest !== e.digest) begin
        $error("state_digest: expected %h actual %h", e.digest, digest);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [63:0] cfg_seed;
  logic in_valid, in_ready;
  logic [1:0] in_command;
  logic in_wide;
  logic [63:0] in_bound_a, in_bound_b;
  logic out_valid, out_ready;
  logic [63:0] out_value, out_state_digest;

  draw_scoreboard sb;
  int idle_cycles;
  bit hold_off;

  xoshiro_uniform_rng_core u_dut (.*);

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_seed = '0;
    in_valid = 1'b0;
    in_command = xur_pkg::CMD_RAW;
    in_wide = 1'b0;
    in_bound_a = '0;
    in_bound_b = '0;
    out_ready = 1'b0;
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_value, out_state_digest);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int w;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_request(xur_pkg::cmd_t cmd, bit wide, logic [63:0] a,
                              logic [63:0] b, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 17) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_wide <= wide;
    in_bound_a <= a;
    in_bound_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(cmd, wide, a, b);
  endtask

  task automatic write_seed(logic [63:0] s);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_seed <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.reseed(s);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_request(bit gaps);
    xur_pkg::cmd_t cmd;
    bit wide;
    logic [63:0] a, b;
    int k;
    cmd = xur_pkg::cmd_t'($urandom_range(0, 3));
    wide = 1'($urandom_range(0, 1));
    a = rand64();
    k = $urandom_range(0, 3);
    case (k)
      0: b = a + $urandom_range(0, 20);
      1: b = a - $urandom_range(0, 1000);
      2: b = {a[63:32], $urandom()};
      default: b = rand64();
    endcase
    if ($urandom_range(0, 15) == 0) begin
      a = 64'd0;
      b = ~64'd0;
    end
    send_request(cmd, wide, a, b, gaps);
  endtask

  initial begin
    logic [63:0] seeds[4];
    seeds[0] = 64'd0;
    seeds[1] = ~64'd0;
    seeds[2] = 64'h0123_4567_89AB_CDEF;
    seeds[3] = 64'h8000_0000_0000_0001;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_request(xur_pkg::CMD_RAW, 1'b1, 64'd0, 64'd0, 1'b0);
    send_request(xur_pkg::CMD_RAW, 1'b0, ~64'd0, ~64'd0, 1'b0);
    send_request(xur_pkg::CMD_SPARE, 1'b1, 64'd5, 64'd9, 1'b0);
    send_request(xur_pkg::CMD_SPARE, 1'b0, 64'd5, 64'd9, 1'b0);
    send_request(xur_pkg::CMD_RANGE, 1'b1, 64'd0, ~64'd0, 1'b0);
    send_request(xur_pkg::CMD_RANGE, 1'b0, 64'hFFFF_FFFF_0000_0000,
                 64'h0000_0000_FFFF_FFFF, 1'b0);
    send_request(xur_pkg::CMD_SIGNED, 1'b1, xur_pkg::SIGN64, ~xur_pkg::SIGN64, 1'b0);
    send_request(xur_pkg::CMD_SIGNED, 1'b0, 64'h8000_0000, 64'h7FFF_FFFF, 1'b0);
    send_request(xur_pkg::CMD_RANGE, 1'b1, 64'd100, 64'd10, 1'b0);
    send_request(xur_pkg::CMD_RANGE, 1'b0, 64'd7, 64'd7, 1'b0);
    send_request(xur_pkg::CMD_RANGE, 1'b1, 64'd0, 64'h8000_0000_0000_0000, 1'b0);
    send_request(xur_pkg::CMD_RANGE, 1'b0, 64'd0, 64'h8000_0000, 1'b0);
    send_request(xur_pkg::CMD_RANGE, 1'b1, 64'd1, ~64'd0, 1'b0);
    send_request(xur_pkg::CMD_SIGNED, 1'b1, 64'd5, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0);
    send_request(xur_pkg::CMD_SIGNED, 1'b0, 64'hABCD_0000_FFFF_FFF0,
                 64'h1234_0000_0000_0010, 1'b0);
    send_request(xur_pkg::CMD_RANGE, 1'b1, ~64'd0, ~64'd0 - 64'd2, 1'b0);
    send_request(xur_pkg::CMD_SIGNED, 1'b1, 64'd0, 64'd0, 1'b0);

    for (int p = 0; p < 4; p++) begin
      write_seed(seeds[p]);
      for (int i = 0; i < 110; i++) begin
        if (p == 1 && i == 30) hold_off = 1'b1;
        random_request((i % 40) >= 10);
      end
    end
    write_seed(rand64());
    for (int i = 0; i < 60; i++) random_request(1'b1);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/xur_pkg.sv
hdl/xur_mul.sv
hdl/xur_mod.sv
hdl/xoshiro_uniform_rng_core.sv
bench/xoshiro_uniform_rng_core_tb.sv
